[design/sqe_pkg.sv]
// ----------------------------------------------------------------------------
// sqe_pkg: shared types and codes of the stack/queue engine
// Request and response payload structs, operation and status codes, and the
// default store depth.
// ----------------------------------------------------------------------------
package sqe_pkg;

  // Default number of words in the store.
  localparam int SQE_DEPTH = 64;

  // Configuration port.
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] REG_STACK_MODE = 2'd0;

  // Operation codes.
  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_DUMP = 3'd1;
  localparam logic [2:0] OP_PEEK = 3'd2;
  localparam logic [2:0] OP_POP  = 3'd3;
  localparam logic [2:0] OP_SWAP = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] push_value;
  } req_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [1:0]         status;
    logic               last;
  } rsp_t;

endpackage

[design/stack_queue_engine_core.sv]
// ----------------------------------------------------------------------------
// stack_queue_engine_core: bounded stack / queue of signed 32-bit words
// The words sit in a circular RAM. The top is at top_ptr and older entries
// follow at rising addresses. Push adds at the top in stack mode and at the
// tail in queue mode; pop, peek and swap act on the top; dump reads every
// entry from the top down.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   req       in         req_valid/req_stall  sqe_pkg::req_t (op, push_value)
//   rsp       out        rsp_valid/rsp_stall  sqe_pkg::rsp_t (data, status, last)
//   config    in         APB psel/penable     stack_mode at byte address 0
//
// A new request is accepted only once the sequencer is back in idle; the RAM
// read and write ports share one address from the shared address adder.
// Reset (rst, synchronous) empties the store and selects stack mode; the RAM
// contents are not cleared, since only entries inside the count are read.
// The response sits in an output register, so a new request is accepted while
// the previous response is still stalled; the sequencer only waits on the
// output register when it has a further response to load.
// ----------------------------------------------------------------------------
module stack_queue_engine_core #(
  parameter int DEPTH = sqe_pkg::SQE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          req_valid,
  output logic                          req_stall,
  input  sqe_pkg::req_t                 req,
  // response channel
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output sqe_pkg::rsp_t                 rsp,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [sqe_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  import sqe_pkg::*;

  // Pointer width indexes the RAM; count width also holds DEPTH itself.
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW:0]   SUM_DEPTH = (PW + 1)'(DEPTH);
  localparam logic [CW-1:0] CNT_FULL  = CW'(DEPTH);
  localparam logic [PW-1:0] OFF_ONE   = PW'(1);
  localparam logic [PW-1:0] OFF_BACK  = PW'(DEPTH - 1);

  // Sequencer states, one-hot.
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_EXEC = 8'b0000_0010,
    S_PEEK = 8'b0000_0100,
    S_SWA  = 8'b0000_1000,
    S_SWB  = 8'b0001_0000,
    S_SWW  = 8'b0010_0000,
    S_DRQ  = 8'b0100_0000,
    S_RESP = 8'b1000_0000
  } state_t;

  state_t state;

  // Architectural state.
  logic [PW-1:0] top_ptr;
  logic [CW-1:0] count;
  logic          stack_mode;

  // Latched request and working registers.
  logic [2:0]         op_r;
  logic signed [31:0] val_r;
  logic [31:0]        tmp;
  logic [PW-1:0]      idx;
  logic signed [31:0] res_data;
  logic [1:0]         res_status;
  logic               res_last;

  // Shared address unit: top_ptr plus an offset, modulo DEPTH.
  logic [PW-1:0] addr_off;
  logic [PW:0]   addr_sum;
  logic [PW-1:0] addr;

  // RAM port.
  logic        ram_we;
  logic        ram_re;
  logic [31:0] ram_wdata;
  logic [31:0] ram_rdata;

  logic empty;
  logic full;
  logic short_store;
  logic out_free;
  logic rsp_load;
  logic cfg_write;
  logic dump_last;

  assign empty       = (count == '0);
  assign full        = (count == CNT_FULL);
  assign short_store = (count < CW'(2));
  assign out_free    = !rsp_valid || !rsp_stall;
  assign rsp_load    = (state == S_RESP) && out_free;
  assign cfg_write   = psel && penable && pwrite && pready;
  assign dump_last   = ((CW'(idx) + CW'(1)) == count);

  assign req_stall = (state != S_IDLE);
  assign pready    = 1'b1;
  assign prdata    = (paddr == REG_STACK_MODE) ? {31'b0, stack_mode} : 32'b0;

  // Offset selection for the address unit. Both pointer moves (stack push
  // and pop) and every RAM address go through the same adder.
  always_comb begin
    addr_off = '0;
    unique case (state)
      S_EXEC: begin
        if (op_r == OP_PUSH) begin
          addr_off = stack_mode ? OFF_BACK : count[PW-1:0];
        end else if (op_r == OP_POP) begin
          addr_off = OFF_ONE;
        end
      end
      S_SWA, S_SWW: addr_off = OFF_ONE;
      S_DRQ:        addr_off = idx;
      default:      addr_off = '0;
    endcase
  end

  assign addr_sum = {1'b0, top_ptr} + {1'b0, addr_off};
  assign addr     = (addr_sum >= SUM_DEPTH) ? PW'(addr_sum - SUM_DEPTH)
                                            : addr_sum[PW-1:0];

  // RAM control.
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_wdata = val_r;
    unique case (state)
      S_EXEC: begin
        ram_we = (op_r == OP_PUSH) && !full;
        ram_re = ((op_r == OP_PEEK) && !empty) ||
                 ((op_r == OP_SWAP) && !short_store);
      end
      S_SWA: ram_re = 1'b1;
      S_SWB: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      S_SWW: begin
        ram_we    = 1'b1;
        ram_wdata = tmp;
      end
      S_DRQ:   ram_re = 1'b1;
      default: ram_we = 1'b0;
    endcase
  end

  sqe_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(addr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(addr),
    .rdata(ram_rdata)
  );

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      top_ptr    <= '0;
      count      <= '0;
      stack_mode <= 1'b1;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_write && (paddr == REG_STACK_MODE)) begin
        stack_mode <= pwdata[0];
      end

      // The output register fills on a load and empties when taken.
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            op_r  <= req.op;
            val_r <= req.push_value;
            state <= S_EXEC;
          end
        end

        S_EXEC: begin
          // Most requests answer with one word of zero data and last set.
          res_data <= '0;
          res_last <= 1'b1;
          unique case (op_r)
            OP_PUSH: begin
              res_status <= full ? ST_FULL : ST_OK;
              state      <= S_RESP;
              if (!full) begin
                if (stack_mode) begin
                  top_ptr <= addr;
                end
                count <= count + CW'(1);
              end
            end
            OP_DUMP: begin
              res_status <= ST_OK;
              idx        <= '0;
              // An empty store dumps nothing and gives no response.
              state      <= empty ? S_IDLE : S_DRQ;
            end
            OP_PEEK: begin
              res_status <= empty ? ST_EMPTY : ST_OK;
              state      <= empty ? S_RESP : S_PEEK;
            end
            OP_POP: begin
              res_status <= empty ? ST_EMPTY : ST_OK;
              state      <= S_RESP;
              if (!empty) begin
                top_ptr <= addr;
                count   <= count - CW'(1);
              end
            end
            OP_SWAP: begin
              res_status <= short_store ? ST_SHORT : ST_OK;
              state      <= short_store ? S_RESP : S_SWA;
            end
            default: begin
              // Unused codes are acknowledged with status ok.
              res_status <= ST_OK;
              state      <= S_RESP;
            end
          endcase
        end

        S_PEEK: begin
          res_data <= ram_rdata;
          state    <= S_RESP;
        end

        // Swap: the top word arrives here while the second is being read.
        S_SWA: begin
          tmp   <= ram_rdata;
          state <= S_SWB;
        end

        // The second word is written over the top.
        S_SWB: begin
          state <= S_SWW;
        end

        // The saved top word goes into the second place.
        S_SWW: begin
          state <= S_RESP;
        end

        // Dump: one read is issued here; the registered word is picked up in the
        // peek state and passed on to the response state below.
        S_DRQ: begin
          res_status <= ST_OK;
          res_last   <= dump_last;
          state      <= S_PEEK;
        end

        S_RESP: begin
          if (out_free) begin
            rsp.data        <= res_data;
            rsp.status      <= res_status;
            rsp.last        <= res_last;
            if ((op_r == OP_DUMP) && !res_last) begin
              idx   <= idx + OFF_ONE;
              state <= S_DRQ;
            end else begin
              state <= S_IDLE;
            end
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // The count never goes past the store size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL)
    else $error("entry count exceeds store depth");

  // A push into a full store leaves count and top pointer alone.
  a_full_push_no_change: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) && (op_r == OP_PUSH) && full |=>
      $stable(count) && $stable(top_ptr))
    else $error("push into full store changed state");

  // The RAM is written only on a push or during the two swap write states.
  a_write_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == S_EXEC) && (op_r == OP_PUSH)) ||
               (state == S_SWB) || (state == S_SWW))
    else $error("unexpected RAM write");

  // A response is loaded only when the output register is free.
  a_resp_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP) && rsp_valid && rsp_stall |=> (state == S_RESP))
    else $error("response state left while output register is stalled");

endmodule

[design/sqe_ram.sv]
// ----------------------------------------------------------------------------
// sqe_ram: generic single-clock RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module sqe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for stack_queue_engine_core
// Sends requests in bursts while the response side stalls on its own pattern.
// A shadow copy of the store predicts every response, and the checker compares
// each response in order. The stack/queue mode is changed over APB while idle.
// ----------------------------------------------------------------------------
module testbench;
  import sqe_pkg::*;

  localparam int DEPTH         = SQE_DEPTH;
  // Quiet cycles on both channels and the APB port before the run is abandoned.
  localparam int IDLE_LIMIT    = 4000;
  // Pause after the last response. An empty dump gives no response, but the
  // core may still be busy with it.
  localparam int SETTLE_CYCLES = 16;
  localparam int MAX_REPORTS   = 10;

  // Codes the core does not decode. It must answer them with a plain OK.
  localparam logic [2:0] OP_NOP5 = 3'd5;
  localparam logic [2:0] OP_NOP6 = 3'd6;
  localparam logic [2:0] OP_NOP7 = 3'd7;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_stall;
  rsp_t        rsp;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the store. The top word sits at shadow_top, and older words
  // follow at rising indices modulo DEPTH.
  logic [31:0] shadow_words [DEPTH];
  int          shadow_top;
  int          shadow_count;
  logic        shadow_stack_mode;

  // Responses predicted but not yet seen, oldest first.
  rsp_t        awaited_rsp [$];
  int          mismatches;
  int          burst_left;
  int          quiet_cycles = 0;

  stack_queue_engine_core #(
    .DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch: %s", msg);
    end
  endfunction

  function automatic rsp_t make_rsp(input logic [31:0] data, input logic [1:0] status,
                                    input logic last);
    rsp_t r;
    r.data   = data;
    r.status = status;
    r.last   = last;
    return r;
  endfunction

  // Push values lean toward the extremes of the signed range.
  function automatic logic [31:0] random_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  // Applies one accepted request to the shadow store and queues the responses
  // that it must produce. Every error case leaves the store unchanged.
  function automatic void predict_store_op(input req_t r);
    int          slot;
    logic [31:0] held;
    case (r.op)
      OP_PUSH: begin
        if (shadow_count >= DEPTH) begin
          awaited_rsp.push_back(make_rsp('0, ST_FULL, 1'b1));
        end else begin
          if (shadow_stack_mode) begin
            shadow_top = (shadow_top + DEPTH - 1) % DEPTH;
            slot = shadow_top;
          end else begin
            slot = (shadow_top + shadow_count) % DEPTH;
          end
          shadow_words[slot] = r.push_value;
          shadow_count++;
          awaited_rsp.push_back(make_rsp('0, ST_OK, 1'b1));
        end
      end
      OP_DUMP: begin
        // An empty store dumps nothing at all.
        for (int i = 0; i < shadow_count; i++) begin
          awaited_rsp.push_back(make_rsp(shadow_words[(shadow_top + i) % DEPTH], ST_OK,
                                         i == shadow_count - 1));
        end
      end
      OP_PEEK: begin
        if (shadow_count == 0) begin
          awaited_rsp.push_back(make_rsp('0, ST_EMPTY, 1'b1));
        end else begin
          awaited_rsp.push_back(make_rsp(shadow_words[shadow_top], ST_OK, 1'b1));
        end
      end
      OP_POP: begin
        if (shadow_count == 0) begin
          awaited_rsp.push_back(make_rsp('0, ST_EMPTY, 1'b1));
        end else begin
          shadow_top = (shadow_top + 1) % DEPTH;
          shadow_count--;
          awaited_rsp.push_back(make_rsp('0, ST_OK, 1'b1));
        end
      end
      OP_SWAP: begin
        if (shadow_count < 2) begin
          awaited_rsp.push_back(make_rsp('0, ST_SHORT, 1'b1));
        end else begin
          slot = (shadow_top + 1) % DEPTH;
          held = shadow_words[shadow_top];
          shadow_words[shadow_top] = shadow_words[slot];
          shadow_words[slot] = held;
          awaited_rsp.push_back(make_rsp('0, ST_OK, 1'b1));
        end
      end
      default: begin
        awaited_rsp.push_back(make_rsp('0, ST_OK, 1'b1));
      end
    endcase
  endfunction

  // Sends one request. The sender works in bursts of random length. Between
  // bursts it drops valid for a random gap, which is sometimes zero, so that
  // back-to-back stretches occur as well. Valid stays high from one request
  // to the next inside a burst.
  task automatic send_request(input logic [2:0] op, input logic [31:0] value);
    req_t item;
    int   gap;
    item.op         = op;
    item.push_value = value;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 20);
      repeat (gap) begin
        @(negedge clk);
        req_valid <= 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predict_store_op(item);
  endtask

  // Draws one random request. Push and pop have the given weights in percent.
  // The rest is split among peek, swap, dump and the undecoded codes.
  task automatic send_random_op(input int push_pct, input int pop_pct);
    int draw;
    int pick;
    draw = $urandom_range(0, 99);
    pick = $urandom_range(0, 19);
    if (draw < push_pct) begin
      send_request(OP_PUSH, random_word());
    end else if (draw < push_pct + pop_pct) begin
      send_request(OP_POP, $urandom());
    end else if (pick < 6) begin
      send_request(OP_PEEK, $urandom());
    end else if (pick < 12) begin
      send_request(OP_SWAP, $urandom());
    end else if (pick < 15) begin
      send_request(OP_DUMP, $urandom());
    end else begin
      send_request(OP_NOP5 + 3'($urandom_range(0, 2)), $urandom());
    end
  endtask

  // Drops valid, waits until every predicted response has come, and then
  // gives the core time to finish any request that makes no response.
  task automatic wait_for_responses();
    @(negedge clk);
    req_valid <= 1'b0;
    burst_left = 0;
    while (awaited_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Reads the mode register over APB and checks bit 0.
  task automatic check_stack_mode(input logic want);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= REG_STACK_MODE;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[0] !== want) begin
      flag_mismatch($sformatf("stack_mode read: expected %0b, got %0b", want, prdata[0]));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes the mode register once the core is idle, and then reads it back.
  // Only bit 0 is defined, so the upper write bits are random.
  task automatic write_stack_mode(input logic mode);
    wait_for_responses();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_STACK_MODE;
    pwdata  <= {31'($urandom()), mode};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    shadow_stack_mode = mode;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    check_stack_mode(mode);
  endtask

  // Reset state, the error responses on an empty or one-entry store, the
  // extremes of the value range, every operation and the undecoded codes.
  // All of it runs in stack mode.
  task automatic test_reset_and_edge_cases();
    check_stack_mode(1'b1);
    send_request(OP_PEEK, $urandom());
    send_request(OP_POP, $urandom());
    send_request(OP_SWAP, $urandom());
    send_request(OP_DUMP, $urandom());
    send_request(OP_PUSH, 32'h7fff_ffff);
    send_request(OP_SWAP, $urandom());
    send_request(OP_PUSH, 32'h8000_0000);
    send_request(OP_PUSH, 32'h0000_0000);
    send_request(OP_PUSH, 32'hffff_ffff);
    send_request(OP_PEEK, $urandom());
    send_request(OP_SWAP, $urandom());
    send_request(OP_PEEK, $urandom());
    send_request(OP_DUMP, $urandom());
    send_request(OP_NOP5, $urandom());
    send_request(OP_NOP6, $urandom());
    send_request(OP_NOP7, $urandom());
    send_request(OP_POP, $urandom());
    send_request(OP_POP, $urandom());
    send_request(OP_DUMP, $urandom());
    send_request(OP_POP, $urandom());
    send_request(OP_POP, $urandom());
    send_request(OP_POP, $urandom());
    send_request(OP_PEEK, $urandom());
    write_stack_mode(1'b1);
  endtask

  // Fills the store to half in one mode. It then flips the mode with data
  // still held and fills to the limit. Next come pushes into the full store
  // and a dump of all of it. The run then flips back and drains to empty.
  // Most of the fill and drain is pushes and pops respectively, with the
  // other operations mixed in at random.
  task automatic test_fill_and_drain(input logic first_mode);
    write_stack_mode(first_mode);
    while (shadow_count < DEPTH / 2) send_random_op(85, 4);
    write_stack_mode(!first_mode);
    while (shadow_count < DEPTH) send_random_op(85, 4);
    repeat (3) send_request(OP_PUSH, random_word());
    send_request(OP_PEEK, $urandom());
    send_request(OP_SWAP, $urandom());
    send_request(OP_DUMP, $urandom());
    write_stack_mode(first_mode);
    while (shadow_count > 0) send_random_op(4, 80);
    send_request(OP_POP, $urandom());
    send_request(OP_SWAP, $urandom());
  endtask

  // The response side stalls in segments. Each segment follows one pattern:
  // no stall, light random stalls, heavy random stalls, or a phase-counter
  // rhythm. Gaps therefore fall on every phase of a request and of a dump.
  initial begin : rsp_stall_pattern
    int seg_left;
    int style;
    int phase;
    rsp_stall = 1'b0;
    seg_left  = 0;
    style     = 0;
    phase     = 0;
    forever begin
      @(negedge clk);
      if (seg_left == 0) begin
        style    = $urandom_range(0, 3);
        seg_left = $urandom_range(20, 120);
      end
      seg_left--;
      phase++;
      case (style)
        0: rsp_stall <= 1'b0;
        1: rsp_stall <= ($urandom_range(0, 99) < 30);
        2: rsp_stall <= ($urandom_range(0, 99) < 75);
        default: rsp_stall <= ((phase % 5) < 2);
      endcase
    end
  end

  // Each accepted response is compared with the oldest prediction.
  always @(posedge clk) begin : rsp_checker
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited_rsp.size() == 0) begin
        flag_mismatch($sformatf("unexpected response data=%h status=%0d last=%0b",
                                rsp.data, rsp.status, rsp.last));
      end else begin
        want = awaited_rsp.pop_front();
        if (rsp.data !== want.data || rsp.status !== want.status ||
            rsp.last !== want.last) begin
          flag_mismatch($sformatf({"expected data=%h status=%0d last=%0b, ",
                                   "got data=%h status=%0d last=%0b"},
                                  want.data, want.status, want.last,
                                  rsp.data, rsp.status, rsp.last));
        end
      end
    end
  end

  // Ends the run if nothing moves on either channel or the APB port for too long.
  always @(posedge clk) begin : watchdog
    if (rst || psel || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[stack_queue_engine_core] ERROR");
      $finish;
    end
  end

  initial begin
    rst               = 1'b1;
    req_valid         = 1'b0;
    req               = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    mismatches        = 0;
    burst_left        = 0;
    shadow_top        = 0;
    shadow_count      = 0;
    shadow_stack_mode = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_and_edge_cases();
    test_fill_and_drain(1'b0);
    test_fill_and_drain(1'b1);
    wait_for_responses();

    if (mismatches == 0) begin
      $display("[stack_queue_engine_core] OK");
    end else begin
      $display("[stack_queue_engine_core] ERROR");
    end
    $finish;
  end

endmodule

[files.f]
design/sqe_pkg.sv
design/sqe_ram.sv
design/stack_queue_engine_core.sv
tb/sv/testbench.sv
